### sv/cpps_pkg.sv
// cpps_pkg: shared types, register indexes and defaults for the charge pump path selector
// no dependencies; imported by every module of the block

package cpps_pkg;

   localparam int unsigned CNT_W          = 8;
   localparam int unsigned DWELL_W        = 16;
   localparam int unsigned CSR_W          = 16;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned VOLT_W         = 15;
   localparam int unsigned RATIO_W        = 3;
   localparam int unsigned DEF_AUX_CHECKS = 10;
   localparam int unsigned DEF_MAX_ERRORS = 3;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CUR_TH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TIME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CUR_TH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TIME     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_INTV    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VOUT_TOL     = 3'd6;

   // request op codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_RESET = 1'b1;

   // divider operand select
   localparam logic DIV_SEL_HIGH = 1'b0;
   localparam logic DIV_SEL_LOW  = 1'b1;

   typedef struct packed {
      logic               op;
      logic [15:0]        bus_current_ma;
      logic               current_valid;
      logic               stop_charging;
      logic               aux_open;
      logic [RATIO_W-1:0] aux_ratio;
      logic [VOLT_W-1:0]  rx_vout_mv;
      logic [VOLT_W-1:0]  aux_vout_mv;
      logic [VOLT_W-1:0]  switch_vbus_mv;
   } req_payload_type;

   typedef struct packed {
      logic dual_path;
      logic went_dual;
      logic went_single;
      logic aux_fault;
      logic locked_out;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_sel;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

### sv/cpps_stream_if.sv
// cpps_stream_if: valid/ready channel carrying one payload per request
// payload type is set per instance from the types in cpps_pkg

interface cpps_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### sv/cpps_div.sv
// cpps_div: restoring divider, one quotient bit per cycle
// depends on cpps_pkg for the operand width

module cpps_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cpps_pkg::DWELL_W-1:0] dividend,
   input  logic [cpps_pkg::DWELL_W-1:0] divisor,
   output logic                         done,
   output logic [cpps_pkg::DWELL_W-1:0] quotient
);
   import cpps_pkg::*;

   localparam int unsigned STEP_W = $clog2(DWELL_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DWELL_W - 1);

   logic [DWELL_W-1:0] rem_ff, rem_in;
   logic [DWELL_W-1:0] quot_ff, quot_in;
   logic [DWELL_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DWELL_W:0]   shifted;
   logic [DWELL_W:0]   diff;
   logic               fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[DWELL_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DWELL_W-1:0] : shifted[DWELL_W-1:0];
         quot_in = {quot_ff[DWELL_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### sv/cpps_dp.sv
// cpps_dp: config registers, path state, aux check and result register
// depends on cpps_pkg and cpps_div; driven by cpps_ctrl through dp_cmd_type

module cpps_dp #(
   parameter int unsigned AUX_CHECKS = cpps_pkg::DEF_AUX_CHECKS,
   parameter int unsigned MAX_ERRORS = cpps_pkg::DEF_MAX_ERRORS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cpps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpps_pkg::CSR_W-1:0]     csr_wdata,
   input  cpps_pkg::req_payload_type      req_payload,
   input  cpps_pkg::dp_cmd_type           cmd,
   output cpps_pkg::dp_status_type        status,
   output cpps_pkg::rsp_payload_type      rsp_payload
);
   import cpps_pkg::*;

   localparam logic [CNT_W-1:0] AUX_CHECKS_C = CNT_W'(AUX_CHECKS);
   localparam logic [CNT_W-1:0] MAX_ERRORS_C = CNT_W'(MAX_ERRORS);
   localparam int unsigned PROD_W = VOLT_W + RATIO_W;

   // configuration
   logic               multi_en_ff;
   logic [CSR_W-1:0]   high_th_ff, high_time_ff, low_th_ff, low_time_ff;
   logic [CSR_W-1:0]   intv_ff, tol_ff;

   // path state
   logic               mode_ff, mode_in;
   logic [CNT_W-1:0]   checks_ff, checks_in;
   logic [CNT_W-1:0]   errors_ff, errors_in;
   logic [DWELL_W-1:0] hdwell_ff, hdwell_in;
   logic [DWELL_W-1:0] ldwell_ff, ldwell_in;

   // per-request working registers
   req_payload_type    item_ff;
   logic [DWELL_W-1:0] qhi_ff, qlo_ff;
   logic               sel_ff;
   logic [PROD_W-1:0]  prod_ff;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               div_done;
   logic [DWELL_W-1:0] div_quot;
   logic [VOLT_W-1:0]  aux_v;
   logic               aux_ok;
   logic               acting;
   logic               fault;
   logic               mode_a;
   logic [CNT_W-1:0]   err_a;
   logic [DWELL_W-1:0] hd_inc, ld_inc;

   cpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ((cmd.div_sel == DIV_SEL_HIGH) ? high_time_ff : low_time_ff),
      .divisor  (intv_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         multi_en_ff  <= 1'b0;
         high_th_ff   <= '0;
         high_time_ff <= '0;
         low_th_ff    <= '0;
         low_time_ff  <= '0;
         intv_ff      <= '0;
         tol_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MULTI_ENABLE: multi_en_ff  <= csr_wdata[0];
            CSR_HIGH_CUR_TH:  high_th_ff   <= csr_wdata;
            CSR_HIGH_TIME:    high_time_ff <= csr_wdata;
            CSR_LOW_CUR_TH:   low_th_ff    <= csr_wdata;
            CSR_LOW_TIME:     low_time_ff  <= csr_wdata;
            CSR_TICK_INTV:    intv_ff      <= csr_wdata;
            CSR_VOUT_TOL:     tol_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture request, divider results and aux product
   assign aux_v = (item_ff.aux_vout_mv != '0) ? item_ff.aux_vout_mv : item_ff.switch_vbus_mv;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.div_start) begin
         sel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         if (sel_ff == DIV_SEL_HIGH) begin
            qhi_ff <= div_quot;
         end else begin
            qlo_ff <= div_quot;
         end
      end
      prod_ff <= PROD_W'(aux_v) * PROD_W'(item_ff.aux_ratio);
   end

   // window check against rx voltage, widened so nothing wraps
   assign aux_ok = item_ff.aux_open
                 && !(({1'b0, prod_ff} + (PROD_W+1)'(tol_ff)) < (PROD_W+1)'(item_ff.rx_vout_mv))
                 && !(prod_ff > PROD_W'((CSR_W+1)'(item_ff.rx_vout_mv) + (CSR_W+1)'(tol_ff)));

   assign acting = (item_ff.op == OP_TICK) && multi_en_ff && (errors_ff < MAX_ERRORS_C)
                 && !item_ff.stop_charging;
   assign hd_inc = (hdwell_ff == '1) ? hdwell_ff : hdwell_ff + DWELL_W'(1);
   assign ld_inc = (ldwell_ff == '1) ? ldwell_ff : ldwell_ff + DWELL_W'(1);

   always_comb begin
      mode_in   = mode_ff;
      checks_in = checks_ff;
      errors_in = errors_ff;
      hdwell_in = hdwell_ff;
      ldwell_in = ldwell_ff;
      rsp_in    = '0;
      fault     = 1'b0;
      mode_a    = mode_ff;
      err_a     = errors_ff;
      if (item_ff.op == OP_RESET) begin
         if (multi_en_ff) begin
            rsp_in.went_single = mode_ff;
            checks_in          = '0;
            errors_in          = '0;
            mode_in            = 1'b0;
         end
      end else if (acting) begin
         // aux check while checks remain
         if (mode_ff && checks_ff != '0) begin
            checks_in = checks_ff - CNT_W'(1);
            if (!aux_ok) begin
               fault              = 1'b1;
               errors_in          = (errors_ff == '1) ? errors_ff : errors_ff + CNT_W'(1);
               checks_in          = '0;
               mode_in            = 1'b0;
               rsp_in.went_single = 1'b1;
            end
         end
         mode_a = mode_in;
         err_a  = errors_in;
         // enter dual
         if (!mode_a && item_ff.current_valid) begin
            if (item_ff.bus_current_ma < high_th_ff || err_a >= MAX_ERRORS_C) begin
               hdwell_in = '0;
            end else begin
               hdwell_in = hd_inc;
               if (intv_ff != '0 && hd_inc >= qhi_ff) begin
                  checks_in        = AUX_CHECKS_C;
                  mode_in          = 1'b1;
                  rsp_in.went_dual = 1'b1;
               end
            end
         end
         // leave dual
         if (mode_in && item_ff.current_valid) begin
            if (item_ff.bus_current_ma > low_th_ff) begin
               ldwell_in = '0;
            end else begin
               ldwell_in = ld_inc;
               if (intv_ff != '0 && ld_inc >= qlo_ff) begin
                  checks_in          = '0;
                  mode_in            = 1'b0;
                  rsp_in.went_single = 1'b1;
               end
            end
         end
      end
      rsp_in.dual_path  = mode_in;
      rsp_in.aux_fault  = fault;
      rsp_in.locked_out = errors_in >= MAX_ERRORS_C;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         checks_ff <= '0;
         errors_ff <= '0;
         hdwell_ff <= '0;
         ldwell_ff <= '0;
      end else if (cmd.commit) begin
         mode_ff   <= mode_in;
         checks_ff <= checks_in;
         errors_ff <= errors_in;
         hdwell_ff <= hdwell_in;
         ldwell_ff <= ldwell_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

### sv/cpps_ctrl.sv
// cpps_ctrl: sequencer for one request: two divisions, then state update
// depends on cpps_pkg; owns the request ready and response valid

module cpps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cpps_pkg::dp_status_type status,
   output cpps_pkg::dp_cmd_type    cmd
);
   import cpps_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV_HI = 4'b0010,
      ST_DIV_LO = 4'b0100,
      ST_UPDATE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // result register can take a new result once the old one leaves
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.div_sel   = DIV_SEL_HIGH;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_HI;
            end
         end
         ST_DIV_HI: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_LOW;
               state_in      = ST_DIV_LO;
            end
         end
         ST_DIV_LO: begin
            if (status.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/charge_pump_path_selector.sv
// charge_pump_path_selector: single/dual charge pump path decision, one request at a time
// a request runs both divisions and the state update before the next request is taken
// the shared 16-step divider is run once per dwell threshold, high then low
// the result register frees the request side while a result waits to be taken
// reset: synchronous, clears config, mode, check, error and dwell counts, no clearing pass
// depends on cpps_pkg, cpps_stream_if, cpps_ctrl, cpps_dp, cpps_div

module charge_pump_path_selector #(
   parameter int unsigned AUX_CHECKS = cpps_pkg::DEF_AUX_CHECKS,
   parameter int unsigned MAX_ERRORS = cpps_pkg::DEF_MAX_ERRORS
) (
   input  logic                           clock,
   input  logic                           reset,
   cpps_stream_if.sink                    req,
   cpps_stream_if.source                  rsp,
   input  logic                           csr_we,
   input  logic [cpps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpps_pkg::CSR_W-1:0]     csr_wdata
);
   import cpps_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   cpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpps_dp #(
      .AUX_CHECKS (AUX_CHECKS),
      .MAX_ERRORS (MAX_ERRORS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp.payload)
   );

endmodule

### sv/cpps_checker.sv
// cpps_checker: port-level checks of the path selector over time
// depends on cpps_pkg; bound to charge_pump_path_selector below

module cpps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input cpps_pkg::rsp_payload_type rsp_payload
);
   import cpps_pkg::*;

   // a waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a failed aux check always reports a switch to single path
   // (the same tick may enter dual again when the error count allows it)
   a_fault_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.aux_fault |-> rsp_payload.went_single)
      else $error("aux fault without switch to single path");

   // no entry into dual path under lockout
   a_lock_no_dual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.locked_out |-> !rsp_payload.went_dual)
      else $error("dual path entered while locked out");

   a_dual_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.went_dual && !rsp_payload.went_single |-> rsp_payload.dual_path)
      else $error("switch to dual not shown in mode");

endmodule

bind charge_pump_path_selector cpps_checker u_cpps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
